### rtl/fsf_pkg.sv
`default_nettype none

package fsf_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_FILL = 2'd0;
    localparam op_t OP_DISC = 2'd1;
    localparam op_t OP_RECT = 2'd2;
    localparam op_t OP_READ = 2'd3;

    localparam int unsigned CFG_WIDTH = 9;
    localparam int unsigned PIXEL_WIDTH = 8;
    localparam int unsigned COORD_WIDTH = 8;
    localparam int unsigned RADIUS_WIDTH = 7;

    typedef logic [PIXEL_WIDTH-1:0] pixel_t;

endpackage

`default_nettype wire

### rtl/fsf_ram.sv
`default_nettype none

module fsf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/framebuffer_shape_fill.sv
`default_nettype none

// channel | signals                                                                   | dir
// --------+---------------------------------------------------------------------------+-----
// in      | in_valid in_ready op pos_x pos_y disc_radius rect_width rect_height color | in
// out     | out_valid out_ready read_value clipped                                    | out
// cfg     | cfg_valid cfg_ready cfg_index cfg_data                                    | in
//
// a command walks its shape one pixel a cycle through the single write port of
// the pixel ram; before each row the shared multiplier forms the row base address,
// then, for every op but a read, the disc row term.
// reset clears control only, not the pixel ram. in_ready is high whenever the sequencer
// is idle; it holds in its last state only while the output register is still full.

module framebuffer_shape_fill #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire fsf_pkg::op_t                        op,
    input  wire logic [fsf_pkg::COORD_WIDTH-1:0]     pos_x,
    input  wire logic [fsf_pkg::COORD_WIDTH-1:0]     pos_y,
    input  wire logic [fsf_pkg::RADIUS_WIDTH-1:0]    disc_radius,
    input  wire logic [fsf_pkg::CFG_WIDTH-1:0]       rect_width,
    input  wire logic [fsf_pkg::CFG_WIDTH-1:0]       rect_height,
    input  wire fsf_pkg::pixel_t                     color,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output fsf_pkg::pixel_t                          read_value,
    output logic                                     clipped,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [fsf_pkg::CFG_WIDTH-1:0]       cfg_data
);

    import fsf_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SETUP   = 3'd1;
    localparam logic [2:0] ST_ROW_BASE = 3'd2;
    localparam logic [2:0] ST_ROW_DY  = 3'd3;
    localparam logic [2:0] ST_PIX     = 3'd4;
    localparam logic [2:0] ST_RD_ADDR = 3'd5;
    localparam logic [2:0] ST_RD_DATA = 3'd6;
    localparam logic [2:0] ST_FIN     = 3'd7;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [2:0]  state_reg, state_next;

    logic [8:0]  width_cfg_reg, height_cfg_reg;

    op_t         op_reg;
    logic [7:0]  px_reg, py_reg;
    logic [6:0]  r_reg;
    logic [8:0]  rw_reg, rh_reg;
    pixel_t      color_reg;

    logic signed [10:0] col0_reg, row0_reg;
    logic [8:0]  col_last_reg, row_last_reg;
    logic [8:0]  scan_col_reg, scan_row_reg;
    logic [13:0] r2_reg, dy2_reg, dx2_reg;
    logic [AW-1:0] base_reg;
    logic        clip_reg;
    pixel_t      value_reg;

    logic        out_valid_reg;
    pixel_t      out_value_reg;
    logic        out_clip_reg;

    // effective image size
    logic [8:0]  w_eff, h_eff;
    always_comb
    begin
        if (width_cfg_reg == 9'd0)
            w_eff = 9'd1;
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            w_eff = 9'(MAX_WIDTH);
        else
            w_eff = width_cfg_reg;
        if (height_cfg_reg == 9'd0)
            h_eff = 9'd1;
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            h_eff = 9'(MAX_HEIGHT);
        else
            h_eff = height_cfg_reg;
    end

    // disc corner with pull-back
    logic signed [10:0] w_s, h_s, r_s, r2x_s, px_s, py_s, cx_s, cy_s;
    assign w_s   = $signed({2'b00, w_eff});
    assign h_s   = $signed({2'b00, h_eff});
    assign r_s   = $signed({4'b0000, r_reg});
    assign r2x_s = $signed({3'b000, r_reg, 1'b0});
    assign px_s  = $signed({3'b000, px_reg});
    assign py_s  = $signed({3'b000, py_reg});
    assign cx_s  = (px_s >= w_s - r_s) ? (w_s - r2x_s - 11'sd1) : px_s;
    assign cy_s  = (py_s >= h_s - r_s) ? (h_s - r2x_s - 11'sd1) : py_s;

    // rectangle extent
    logic [9:0]  xe, ye;
    logic        xe_over, ye_over, px_out, py_out, rect_empty, rect_clip;
    logic [8:0]  xe_c, ye_c, rect_col_last, rect_row_last;
    assign xe      = {2'b00, px_reg} + {1'b0, rw_reg};
    assign ye      = {2'b00, py_reg} + {1'b0, rh_reg};
    assign xe_over = xe > {1'b0, w_eff};
    assign ye_over = ye > {1'b0, h_eff};
    assign px_out  = {1'b0, px_reg} >= w_eff;
    assign py_out  = {1'b0, py_reg} >= h_eff;
    assign xe_c    = xe_over ? w_eff : xe[8:0];
    assign ye_c    = ye_over ? h_eff : ye[8:0];
    assign rect_empty = (rw_reg == 9'd0) || (rh_reg == 9'd0) || px_out || py_out;
    assign rect_clip  = (rw_reg != 9'd0) && (rh_reg != 9'd0)
                        && (xe_over || ye_over || px_out || py_out);
    assign rect_col_last = xe_c - {1'b0, px_reg} - 9'd1;
    assign rect_row_last = ye_c - {1'b0, py_reg} - 9'd1;

    // current position
    logic signed [10:0] col_cur, row_cur;
    logic        in_image;
    assign col_cur  = col0_reg + $signed({2'b00, scan_col_reg});
    assign row_cur  = row0_reg + $signed({2'b00, scan_row_reg});
    assign in_image = !col_cur[10] && !row_cur[10]
                      && (col_cur[9:0] < {1'b0, w_eff})
                      && (row_cur[9:0] < {1'b0, h_eff});

    // disc row and column offsets from the center
    logic signed [9:0]  dy, dx;
    logic [9:0]  dy_abs;
    logic signed [10:0] dx_step;
    logic signed [15:0] dx2_sum;
    logic        in_disc, in_shape;
    assign dy      = $signed({1'b0, scan_row_reg}) - $signed({3'b000, r_reg});
    assign dy_abs  = dy[9] ? 10'(-dy) : 10'(dy);
    assign dx      = $signed({1'b0, scan_col_reg}) - $signed({3'b000, r_reg});
    assign dx_step = $signed({dx, 1'b1});
    assign dx2_sum = $signed({2'b00, dx2_reg}) + $signed({{5{dx_step[10]}}, dx_step});
    assign in_disc = ({1'b0, dx2_reg} + {1'b0, dy2_reg}) <= {1'b0, r2_reg};
    assign in_shape = (op_reg != OP_DISC) || in_disc;

    // shared multiplier
    logic [8:0]  mul_a, mul_b;
    logic [17:0] mul_p;
    always_comb
    begin
        case (state_reg)
            ST_SETUP:
            begin
                mul_a = {2'b00, r_reg};
                mul_b = {2'b00, r_reg};
            end
            ST_ROW_BASE:
            begin
                mul_a = row_cur[8:0];
                mul_b = w_eff;
            end
            ST_ROW_DY:
            begin
                mul_a = dy_abs[8:0];
                mul_b = dy_abs[8:0];
            end
            default:
            begin
                mul_a = 9'd0;
                mul_b = 9'd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // pixel ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    pixel_t        ram_rdata;
    assign ram_we    = (state_reg == ST_PIX) && in_image && in_shape;
    assign ram_waddr = base_reg + AW'(col_cur[8:0]);
    assign ram_raddr = base_reg + AW'(col0_reg[8:0]);

    fsf_ram #(
        .WIDTH (PIXEL_WIDTH),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (color_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic in_fire, out_free;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                case (op_reg)
                    OP_RECT: state_next = rect_empty ? ST_FIN : ST_ROW_BASE;
                    OP_READ: state_next = (px_out || py_out) ? ST_FIN : ST_ROW_BASE;
                    default: state_next = ST_ROW_BASE;
                endcase
            end
            ST_ROW_BASE:
            begin
                state_next = (op_reg == OP_READ) ? ST_RD_ADDR : ST_ROW_DY;
            end
            ST_ROW_DY:
            begin
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                if (scan_col_reg == col_last_reg)
                    state_next = (scan_row_reg == row_last_reg) ? ST_FIN : ST_ROW_BASE;
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= 9'd256;
            height_cfg_reg <= 9'd256;
            scan_col_reg   <= 9'd0;
            scan_row_reg   <= 9'd0;
            clip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_HEIGHT: height_cfg_reg <= cfg_data;
                    default:    width_cfg_reg  <= width_cfg_reg;
                endcase
            end

            case (state_reg)
                ST_SETUP:
                begin
                    scan_col_reg <= 9'd0;
                    scan_row_reg <= 9'd0;
                    case (op_reg)
                        OP_RECT: clip_reg <= rect_clip;
                        OP_READ: clip_reg <= px_out || py_out;
                        default: clip_reg <= 1'b0;
                    endcase
                end
                ST_PIX:
                begin
                    if ((op_reg == OP_DISC) && in_disc && !in_image)
                        clip_reg <= 1'b1;
                    if (scan_col_reg == col_last_reg)
                    begin
                        scan_col_reg <= 9'd0;
                        if (scan_row_reg != row_last_reg)
                            scan_row_reg <= scan_row_reg + 9'd1;
                    end
                    else
                    begin
                        scan_col_reg <= scan_col_reg + 9'd1;
                    end
                end
                ST_FIN:
                begin
                    scan_col_reg <= 9'd0;
                    scan_row_reg <= 9'd0;
                end
                default:
                begin
                    clip_reg <= clip_reg;
                end
            endcase

            if ((state_reg == ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= op;
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            r_reg     <= disc_radius;
            rw_reg    <= rect_width;
            rh_reg    <= rect_height;
            color_reg <= color;
        end

        case (state_reg)
            ST_SETUP:
            begin
                r2_reg    <= mul_p[13:0];
                value_reg <= '0;
                case (op_reg)
                    OP_FILL:
                    begin
                        col0_reg     <= 11'sd0;
                        row0_reg     <= 11'sd0;
                        col_last_reg <= w_eff - 9'd1;
                        row_last_reg <= h_eff - 9'd1;
                    end
                    OP_DISC:
                    begin
                        col0_reg     <= cx_s;
                        row0_reg     <= cy_s;
                        col_last_reg <= {1'b0, r_reg, 1'b0};
                        row_last_reg <= {1'b0, r_reg, 1'b0};
                    end
                    OP_RECT:
                    begin
                        col0_reg     <= px_s;
                        row0_reg     <= py_s;
                        col_last_reg <= rect_col_last;
                        row_last_reg <= rect_row_last;
                    end
                    default:
                    begin
                        col0_reg     <= px_s;
                        row0_reg     <= py_s;
                        col_last_reg <= 9'd0;
                        row_last_reg <= 9'd0;
                    end
                endcase
            end
            ST_ROW_BASE:
            begin
                base_reg <= AW'(mul_p);
            end
            ST_ROW_DY:
            begin
                dy2_reg <= mul_p[13:0];
                dx2_reg <= r2_reg;
            end
            ST_PIX:
            begin
                dx2_reg <= dx2_sum[13:0];
            end
            ST_RD_DATA:
            begin
                value_reg <= ram_rdata;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_value_reg <= value_reg;
                    out_clip_reg  <= clip_reg;
                end
            end
            default:
            begin
                value_reg <= value_reg;
            end
        endcase
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign clipped    = out_clip_reg;

endmodule

`default_nettype wire

### tb/sv/fsf_tb_pkg.sv
`timescale 1ns / 1ps

package fsf_tb_pkg;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### tb/sv/shape_fill_checker.sv
`timescale 1ns / 1ps

module shape_fill_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire fsf_pkg::op_t                        op,
    input  wire logic [fsf_pkg::COORD_WIDTH-1:0]     pos_x,
    input  wire logic [fsf_pkg::COORD_WIDTH-1:0]     pos_y,
    input  wire logic [fsf_pkg::RADIUS_WIDTH-1:0]    disc_radius,
    input  wire logic [fsf_pkg::CFG_WIDTH-1:0]       rect_width,
    input  wire logic [fsf_pkg::CFG_WIDTH-1:0]       rect_height,
    input  wire fsf_pkg::pixel_t                     color,

    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire fsf_pkg::pixel_t                     read_value,
    input  wire logic                                clipped,

    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [fsf_pkg::CFG_WIDTH-1:0]       cfg_data,

    output int                                       errors,
    output int                                       pending
);

    import fsf_pkg::*;
    import fsf_tb_pkg::*;

    typedef struct packed
    {
        pixel_t read_value;
        logic   clipped;
    } draw_result_t;

    pixel_t                    frame [MAX_WIDTH*MAX_HEIGHT];
    logic [CFG_WIDTH-1:0]      width_reg;
    logic [CFG_WIDTH-1:0]      height_reg;
    draw_result_t              expected_results [$];
    int                        fail_count = 0;
    int                        outstanding = 0;

    assign errors  = fail_count;
    assign pending = outstanding;

    task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
        $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // zero acts as one, anything past the array size acts as the maximum
    function automatic int clamp_dim(logic [CFG_WIDTH-1:0] v, int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    task automatic draw_command(op_t c, int x, int y, int rad, int rw, int rh,
                                pixel_t col, output draw_result_t res);
        int w, h, cx, cy, xe, ye, row, column;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        res = '0;
        case (c)
            OP_FILL:
                for (int k = 0; k < w * h; k++)
                    frame[k] = col;
            OP_DISC:
            begin
                // corner near the far edge is pulled back, possibly below zero
                cx = x;
                cy = y;
                if (cx >= w - rad)
                    cx = w - 2 * rad - 1;
                if (cy >= h - rad)
                    cy = h - 2 * rad - 1;
                for (int j = -rad; j <= rad; j++)
                    for (int i = -rad; i <= rad; i++)
                        if (i * i + j * j <= rad * rad)
                        begin
                            column = rad + i + cx;
                            row = rad + j + cy;
                            if (column < 0 || row < 0 || column >= w || row >= h)
                                res.clipped = 1'b1;
                            else
                                frame[row * w + column] = col;
                        end
            end
            OP_RECT:
            begin
                if (rw > 0 && rh > 0)
                begin
                    xe = x + rw;
                    ye = y + rh;
                    if (xe > w || ye > h || x >= w || y >= h)
                        res.clipped = 1'b1;
                    if (xe > w)
                        xe = w;
                    if (ye > h)
                        ye = h;
                    for (int j = y; j < ye; j++)
                        for (int i = x; i < xe; i++)
                            frame[j * w + i] = col;
                end
            end
            default:
            begin
                if (x >= w || y >= h)
                    res.clipped = 1'b1;
                else
                    res.read_value = frame[y * w + x];
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t seen;
        draw_result_t want;
        if (!rst_n)
        begin
            width_reg = 9'd256;
            height_reg = 9'd256;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                draw_command(op, pos_x, pos_y, disc_radius, rect_width, rect_height,
                             color, want);
                expected_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                seen.read_value = read_value;
                seen.clipped = clipped;
                if (expected_results.size() == 0)
                    report_mismatch("result word with none outstanding", seen, 9'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.read_value !== want.read_value)
                        report_mismatch("read_value", seen.read_value, want.read_value);
                    if (seen.clipped !== want.clipped)
                        report_mismatch("clipped", seen.clipped, want.clipped);
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

### tb/sv/tb_framebuffer_shape_fill.sv
`timescale 1ns / 1ps

module tb_framebuffer_shape_fill;

    import fsf_pkg::*;
    import fsf_tb_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int PRESSURE_PHASE  = 8;
    localparam int FILL_AREA_LIMIT = 4096;

    // register values per random phase, including zero and oversize values
    localparam int PHASE_WIDTH [NUM_PHASES]  = '{16, 1, 0, 37, 256, 3, 511, 64, 255, 2, 200, 16};
    localparam int PHASE_HEIGHT [NUM_PHASES] = '{16, 1, 0, 23, 4, 256, 300, 64, 2, 255, 150, 16};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    op_t                        op;
    logic [COORD_WIDTH-1:0]     pos_x;
    logic [COORD_WIDTH-1:0]     pos_y;
    logic [RADIUS_WIDTH-1:0]    disc_radius;
    logic [CFG_WIDTH-1:0]       rect_width;
    logic [CFG_WIDTH-1:0]       rect_height;
    pixel_t                     color;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    pixel_t                     read_value;
    logic                       clipped;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    int                         fail_total;
    int                         results_outstanding;
    int                         send_idle_pct = 7;
    int                         recv_idle_pct = 59;
    int                         hold_request = 0;
    int                         hold_left = 0;

    always #2 clk = ~clk;

    framebuffer_shape_fill DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .disc_radius (disc_radius),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .color       (color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .clipped     (clipped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    shape_fill_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .disc_radius (disc_radius),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .color       (color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .clipped     (clipped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (fail_total),
        .pending     (results_outstanding)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_command(op_t c, int x, int y, int rad, int rw, int rh, int col);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= c;
        pos_x <= x[COORD_WIDTH-1:0];
        pos_y <= y[COORD_WIDTH-1:0];
        disc_radius <= rad[RADIUS_WIDTH-1:0];
        rect_width <= rw[CFG_WIDTH-1:0];
        rect_height <= rh[CFG_WIDTH-1:0];
        color <= col[PIXEL_WIDTH-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_WIDTH-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_command(int w, int h, bit reads_only);
        int pick, x, y, rad, rw, rh, k;
        op_t c;
        pick = reads_only ? 99 : $urandom_range(0, 99);
        if (pick < 10)
            c = (w * h <= FILL_AREA_LIMIT) ? OP_FILL : OP_RECT;
        else if (pick < 35)
            c = OP_DISC;
        else if (pick < 65)
            c = OP_RECT;
        else
            c = OP_READ;
        // mostly near the image, sometimes anywhere in the coordinate range
        if ($urandom_range(0, 3) == 0)
        begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
        end
        else
        begin
            x = $urandom_range(0, (w + 3 > 255) ? 255 : w + 3);
            y = $urandom_range(0, (h + 3 > 255) ? 255 : h + 3);
        end
        // large discs are slow, keep them rare
        k = $urandom_range(0, 199);
        if (k < 3)
            rad = $urandom_range(31, 127);
        else if (k < 27)
            rad = $urandom_range(13, 30);
        else
            rad = $urandom_range(0, 12);
        k = $urandom_range(0, 99);
        if (k < 8)
        begin
            rw = $urandom_range(0, 511);
            rh = $urandom_range(0, 3);
        end
        else if (k < 16)
        begin
            rw = $urandom_range(0, 3);
            rh = $urandom_range(0, 511);
        end
        else
        begin
            rw = $urandom_range(0, 40);
            rh = $urandom_range(0, 40);
        end
        send_command(c, x, y, rad, rw, rh, $urandom_range(0, 255));
    endtask

    initial
    begin
        int w, h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_FILL;
        pos_x = '0;
        pos_y = '0;
        disc_radius = '0;
        rect_width = '0;
        rect_height = '0;
        color = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-size image after reset; the first fill writes every pixel
        send_command(OP_FILL, 0, 0, 0, 0, 0, 8'hA5);
        send_command(OP_READ, 0, 0, 0, 0, 0, 0);
        send_command(OP_READ, 255, 255, 0, 0, 0, 0);
        send_command(OP_DISC, 0, 0, 0, 0, 0, 8'h00);
        send_command(OP_READ, 0, 0, 0, 0, 0, 0);
        send_command(OP_DISC, 0, 0, 127, 0, 0, 8'hFF);
        send_command(OP_READ, 127, 127, 0, 0, 0, 0);
        // corner at the far edge gets pulled back
        send_command(OP_DISC, 250, 250, 10, 0, 0, 8'h3C);
        send_command(OP_READ, 245, 245, 0, 0, 0, 0);
        send_command(OP_RECT, 0, 0, 0, 256, 1, 8'h5A);
        send_command(OP_RECT, 255, 0, 0, 1, 256, 8'h77);
        send_command(OP_READ, 255, 128, 0, 0, 0, 0);
        send_command(OP_RECT, 200, 200, 0, 100, 100, 8'hC3);
        // empty rectangles draw nothing and do not flag
        send_command(OP_RECT, 10, 10, 0, 511, 0, 8'h12);
        send_command(OP_RECT, 10, 10, 0, 0, 511, 8'h34);

        // small image: negative pull-back, outside reads, clipped rectangles
        drain_results();
        write_register(REG_IMAGE_WIDTH, 16);
        write_register(REG_IMAGE_HEIGHT, 8);
        send_command(OP_DISC, 12, 5, 10, 0, 0, 8'h44);
        send_command(OP_READ, 16, 0, 0, 0, 0, 0);
        send_command(OP_READ, 0, 8, 0, 0, 0, 0);
        send_command(OP_READ, 255, 255, 0, 0, 0, 0);
        send_command(OP_READ, 15, 7, 0, 0, 0, 0);
        send_command(OP_RECT, 10, 5, 0, 20, 20, 8'h66);
        send_command(OP_RECT, 16, 0, 0, 1, 1, 8'h88);
        send_command(OP_FILL, 0, 0, 0, 0, 0, 8'h11);
        send_command(OP_DISC, 3, 2, 2, 0, 0, 8'h99);
        send_command(OP_READ, 5, 4, 0, 0, 0, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_register(REG_IMAGE_WIDTH, PHASE_WIDTH[p]);
            write_register(REG_IMAGE_HEIGHT, PHASE_HEIGHT[p]);
            if (p == 4)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 7;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = (PHASE_WIDTH[p] == 0) ? 1 : (PHASE_WIDTH[p] > 256) ? 256 : PHASE_WIDTH[p];
            h = (PHASE_HEIGHT[p] == 0) ? 1 : (PHASE_HEIGHT[p] > 256) ? 256 : PHASE_HEIGHT[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long result stall while short reads keep coming
                if (p == PRESSURE_PHASE && n == 10)
                    hold_request = 800;
                random_command(w, h, p == PRESSURE_PHASE && n >= 10 && n < 30);
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_total == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
